@@ sv/sphere_mesh_index_generator_assert.svh @@
// Assertion macros shared by the sphere mesh index generator RTL.
// Each macro expands to one labeled concurrent assertion; no other dependencies.
`ifndef SPHERE_MESH_INDEX_GENERATOR_ASSERT_SVH
`define SPHERE_MESH_INDEX_GENERATOR_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define SMIG_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("smig assertion failed");

// Next-cycle implication, disabled during reset.
`define SMIG_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("smig assertion failed");

`endif

@@ sv/smig_pkg.sv @@
// Shared types for the sphere mesh index generator.
// Used by smig_cfg, smig_seq and the top level; depends on nothing.
`default_nettype none

package smig_pkg;

  localparam int unsigned RES_W   = 9;
  localparam int unsigned IDX_W   = 16;
  localparam int unsigned RING_W  = 8;

  // Walk position within the mesh.
  typedef enum logic [2:0] {
    PH_SOUTH = 3'b001,
    PH_RING  = 3'b010,
    PH_NORTH = 3'b100
  } phase_t;

  // Configuration seen by the sequencer: effective resolution and write strobe.
  typedef struct packed {
    logic [RES_W-1:0] res;
    logic             wr;
  } cfg_t;

  // One emitted triangle.
  typedef struct packed {
    logic [IDX_W-1:0] a;
    logic [IDX_W-1:0] b;
    logic [IDX_W-1:0] c;
    logic             last;
  } tri_t;

endpackage

`default_nettype wire

@@ sv/smig_cfg.sv @@
// Resolution register with range clamping for the sphere mesh index generator.
// Depends on smig_pkg for the configuration struct.
`default_nettype none

module smig_cfg #(
  parameter int unsigned MAX_RESOLUTION = 256
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      wr_en,
  input  wire logic [smig_pkg::RES_W-1:0] wr_data,
  output smig_pkg::cfg_t                 cfg
);
  import smig_pkg::*;

  localparam logic [RES_W-1:0] RES_MIN   = RES_W'(3);
  localparam logic [RES_W-1:0] RES_MAX   = RES_W'(MAX_RESOLUTION);
  localparam logic [RES_W-1:0] RES_RESET = RES_W'(16);

  logic [RES_W-1:0] resolution;

  // Raw register value; a write replaces it.
  always_ff @(posedge clk) begin
    if (rst) begin
      resolution <= RES_RESET;
    end else if (wr_en) begin
      resolution <= wr_data;
    end
  end

  // Out-of-range values act as the nearest bound.
  always_comb begin
    if (resolution < RES_MIN) begin
      cfg.res = RES_MIN;
    end else if (resolution > RES_MAX) begin
      cfg.res = RES_MAX;
    end else begin
      cfg.res = resolution;
    end
    cfg.wr = wr_en;
  end

endmodule

`default_nettype wire

@@ sv/smig_seq.sv @@
// Triangle walk state and vertex index computation for the sphere mesh.
// Depends on smig_pkg for the phase type and the config and triangle structs.
`default_nettype none

module smig_seq (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire smig_pkg::cfg_t cfg,
  input  wire logic           step,
  input  wire logic           restart,
  output smig_pkg::tri_t      tri_out
);
  import smig_pkg::*;

  phase_t            phase, phase_next;
  logic [RING_W-1:0] ring_index, ring_index_next;
  logic [RES_W-1:0]  column_index, column_index_next;
  logic              second_of_pair, second_of_pair_next;
  logic [IDX_W-1:0]  lower_ring_base, lower_ring_base_next;
  logic [IDX_W-1:0]  upper_ring_base, upper_ring_base_next;

  phase_t            cur_phase;
  logic [RING_W-1:0] cur_ring;
  logic [RES_W-1:0]  cur_col;
  logic              cur_second;
  logic [IDX_W-1:0]  cur_lower;
  logic [IDX_W-1:0]  cur_upper;

  logic [RES_W-1:0]  col;
  logic [RES_W-1:0]  nxt;
  logic              col_end;
  logic [IDX_W-1:0]  col16;
  logic [IDX_W-1:0]  nxt16;
  logic [IDX_W-1:0]  res16;

  // A restart request sees the walk as if freshly started.
  always_comb begin
    if (restart) begin
      cur_phase  = PH_SOUTH;
      cur_ring   = RING_W'(1);
      cur_col    = RES_W'(1);
      cur_second = 1'b0;
      cur_lower  = '0;
      cur_upper  = '0;
    end else begin
      cur_phase  = phase;
      cur_ring   = ring_index;
      cur_col    = column_index;
      cur_second = second_of_pair;
      cur_lower  = lower_ring_base;
      cur_upper  = upper_ring_base;
    end
  end

  // Column and its wrapping neighbor.
  always_comb begin
    if (cur_col == '0 || cur_col > cfg.res) begin
      col = RES_W'(1);
    end else begin
      col = cur_col;
    end
    col_end = (col >= cfg.res);
    nxt     = col_end ? RES_W'(1) : col + RES_W'(1);
    col16   = IDX_W'(col);
    nxt16   = IDX_W'(nxt);
    res16   = IDX_W'(cfg.res);
  end

  // Triangle corners and the following walk position.
  always_comb begin
    phase_next           = cur_phase;
    ring_index_next      = cur_ring;
    column_index_next    = cur_col;
    second_of_pair_next  = cur_second;
    lower_ring_base_next = cur_lower;
    upper_ring_base_next = cur_upper;
    tri_out.last         = 1'b0;

    case (cur_phase)
      PH_RING: begin
        tri_out.c = col16 + cur_lower;
        if (!cur_second) begin
          tri_out.a           = nxt16 + cur_upper;
          tri_out.b           = col16 + cur_upper;
          second_of_pair_next = 1'b1;
        end else begin
          tri_out.a           = nxt16 + cur_lower;
          tri_out.b           = nxt16 + cur_upper;
          second_of_pair_next = 1'b0;
          if (col_end) begin
            column_index_next = RES_W'(1);
            if ({1'b0, cur_ring} >= cfg.res - RES_W'(3)) begin
              phase_next = PH_NORTH;
            end else begin
              ring_index_next      = cur_ring + RING_W'(1);
              lower_ring_base_next = cur_upper;
              upper_ring_base_next = cur_upper + res16;
            end
          end else begin
            column_index_next = col + RES_W'(1);
          end
        end
      end
      PH_NORTH: begin
        // The upper base of the last ring pair is the top ring's base.
        tri_out.a = nxt16 + cur_upper;
        tri_out.b = cur_upper + res16 + IDX_W'(1);
        tri_out.c = col16 + cur_upper;
        if (col_end) begin
          tri_out.last         = 1'b1;
          phase_next           = PH_SOUTH;
          ring_index_next      = RING_W'(1);
          column_index_next    = RES_W'(1);
          second_of_pair_next  = 1'b0;
          lower_ring_base_next = '0;
          upper_ring_base_next = '0;
        end else begin
          column_index_next = col + RES_W'(1);
        end
      end
      default: begin
        // South cap fan around the pole vertex.
        tri_out.a = nxt16;
        tri_out.b = col16;
        tri_out.c = '0;
        if (col_end) begin
          column_index_next   = RES_W'(1);
          second_of_pair_next = 1'b0;
          if (cfg.res > RES_W'(3)) begin
            phase_next           = PH_RING;
            ring_index_next      = RING_W'(1);
            lower_ring_base_next = '0;
            upper_ring_base_next = res16;
          end else begin
            phase_next = PH_NORTH;
          end
        end else begin
          phase_next        = PH_SOUTH;
          column_index_next = col + RES_W'(1);
        end
      end
    endcase
  end

  // Walk state; a configuration write starts over.
  always_ff @(posedge clk) begin
    if (rst || cfg.wr) begin
      phase           <= PH_SOUTH;
      ring_index      <= RING_W'(1);
      column_index    <= RES_W'(1);
      second_of_pair  <= 1'b0;
      lower_ring_base <= '0;
      upper_ring_base <= '0;
    end else if (step) begin
      phase           <= phase_next;
      ring_index      <= ring_index_next;
      column_index    <= column_index_next;
      second_of_pair  <= second_of_pair_next;
      lower_ring_base <= lower_ring_base_next;
      upper_ring_base <= upper_ring_base_next;
    end
  end

endmodule

`default_nettype wire

@@ sv/sphere_mesh_index_generator.sv @@
// Sphere mesh index generator: emits the vertex indices of a UV sphere's
// triangles, one triangle per request, south cap first, then the ring
// pairs, then the north cap, and wraps after the final triangle.
//
// Request channel: in_valid / in_stall with the restart bit. A request with
// restart set begins again at the first south-cap triangle.
// Result channel: out_valid / out_stall with the three corner indices and
// last_of_mesh. Configuration channel: cfg_valid / cfg_ready with the
// resolution; cfg_ready is always high and every write restarts the walk.
//
// A request transfer loads the request register; the result register is loaded
// from it when the request advances, and the result can then transfer. One
// triangle per cycle is sustained while the receiver does not stall; the walk
// counters and base adders are combinational logic.
// When the receiver stalls, the result register holds and one more request
// can wait in the request register before in_stall rises.
// Synchronous reset empties both registers, sets resolution to 16 and puts
// the walk at the first south-cap triangle.
// Depends on smig_pkg, smig_cfg, smig_seq and the assertion macro header.
`default_nettype none

module sphere_mesh_index_generator #(
  parameter int unsigned MAX_RESOLUTION = 256
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       cfg_valid,
  output wire logic                       cfg_ready,
  input  wire logic [smig_pkg::RES_W-1:0] resolution,
  input  wire logic                       in_valid,
  output wire logic                       in_stall,
  input  wire logic                       restart,
  output logic                            out_valid,
  input  wire logic                       out_stall,
  output logic [smig_pkg::IDX_W-1:0]      corner_first,
  output logic [smig_pkg::IDX_W-1:0]      corner_second,
  output logic [smig_pkg::IDX_W-1:0]      corner_third,
  output logic                            last_of_mesh
);
  import smig_pkg::*;

  `include "sphere_mesh_index_generator_assert.svh"

  cfg_t cfg;
  tri_t tri_comb;

  logic req_valid;
  logic req_restart;
  logic out_ready;
  logic in_take;
  logic advance;

  // Configuration is always accepted.
  assign cfg_ready = 1'b1;

  smig_cfg #(
    .MAX_RESOLUTION (MAX_RESOLUTION)
  ) u_cfg (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (cfg_valid && cfg_ready),
    .wr_data (resolution),
    .cfg     (cfg)
  );

  // Handshake between request register and result register.
  assign out_ready = !out_valid || !out_stall;
  assign advance   = req_valid && out_ready;
  assign in_stall  = req_valid && !out_ready;
  assign in_take   = in_valid && !in_stall;

  smig_seq u_seq (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .step    (advance),
    .restart (req_restart),
    .tri_out (tri_comb)
  );

  // Request register.
  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (in_take) begin
      req_valid <= 1'b1;
    end else if (advance) begin
      req_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      req_restart <= restart;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      corner_first  <= tri_comb.a;
      corner_second <= tri_comb.b;
      corner_third  <= tri_comb.c;
      last_of_mesh  <= tri_comb.last;
    end
  end

  // A request moved forward always lands in the result register.
  `SMIG_ASSERT_NEXT(a_advance_lands, clk, rst, advance, out_valid)
  // A blocked request is neither lost nor overwritten.
  `SMIG_ASSERT_NEXT(a_req_kept, clk, rst, req_valid && !out_ready, req_valid)
  // The closing north-cap triangle spans column 1 and column res.
  `SMIG_ASSERT_NOW(a_last_span, clk, rst, out_valid && last_of_mesh,
    corner_third - corner_first == IDX_W'(cfg.res) - IDX_W'(1))

endmodule

`default_nettype wire
